[hdl/ils_pkg.sv]
`timescale 1ns / 1ps

package ils_pkg;

	// list geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int POS_W    = 7;
	localparam int ST_W     = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
	localparam logic [OP_W-1:0] OP_PREPEND      = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT       = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_GET          = 3'd6;
	localparam logic [OP_W-1:0] OP_SIZE         = 3'd7;

	// status codes
	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	localparam logic signed [DATA_W-1:0] GET_FAIL_VALUE = 32'sh8000_0000;

	// request item
	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value_in;
	} ils_req_t;

	// response item
	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [CNT_W-1:0]         element_count;
		logic [ST_W-1:0]          status;
	} ils_rsp_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [CNT_W-1:0]         at;
		logic signed [DATA_W-1:0] v;
	} ils_shift_t;

endpackage

[hdl/ils_cell.sv]
`timescale 1ns / 1ps

module ils_cell import ils_pkg::*; (
	input  logic                     clk,
	input  logic [CNT_W-1:0]         idx,
	input  ils_shift_t               sh,
	input  logic signed [DATA_W-1:0] below,
	input  logic signed [DATA_W-1:0] above,
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;

	// open a gap at or close a gap over this cell
	always_ff @(posedge clk) begin
		if (sh.ins) begin
			if (idx > sh.at) begin
				data_q <= below;
			end else if (idx == sh.at) begin
				data_q <= sh.v;
			end
		end else if (sh.rem && idx >= sh.at) begin
			data_q <= above;
		end
	end

	assign data = data_q;

endmodule

[hdl/indexed_list_store_top.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Request channel (req_valid/req_ready/req) carries operation, position and
// value_in; response channel (rsp_valid/rsp_ready/rsp) returns one item per
// request with value_out, the element count after the operation and status.
// A request is taken into the request register; once the response register
// is free, all cells shift in parallel (insert or remove) while the get
// multiplexer over the cells loads the response register. No new request is
// taken while one waits in the request register.
// Reset clears the count and both valid flags; cell contents stay undefined
// until written, and only cells below the count are ever read.
// When the receiver stalls, the response holds in its register; one more
// request can be accepted and waits in the request register, after which
// req_ready stays low until the response is taken.
module indexed_list_store_top import ils_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ils_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ils_rsp_t rsp
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic                     busy_q;
	ils_req_t                 req_q;
	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	ils_rsp_t                 rsp_q;
	logic                     exec;
	ils_shift_t               sh;
	logic [CNT_W-1:0]         at;
	logic [CNT_W-1:0]         pos;
	logic                     ins_ok;
	logic                     rem_ok;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] result;
	logic [CNT_W-1:0]         count_nxt;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];

	assign req_ready = !busy_q;
	assign exec      = busy_q && (!rsp_valid_q || rsp_ready);
	assign pos       = CNT_W'(req_q.position);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

	// operation decode
	always_comb begin
		at     = '0;
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		status = ST_DONE;
		result = '0;
		case (req_q.operation)
			OP_APPEND, OP_PREPEND, OP_INSERT: begin
				if (req_q.operation == OP_APPEND) begin
					at = count_q;
				end else if (req_q.operation == OP_INSERT) begin
					at = pos;
				end
				if (at > count_q) begin
					status = ST_IGNORED;
				end else if (count_q == CAP_CNT) begin
					status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_REMOVE_LAST, OP_REMOVE_FIRST, OP_REMOVE_AT: begin
				if (req_q.operation == OP_REMOVE_LAST) begin
					at = count_q - CNT_W'(1);
				end else if (req_q.operation == OP_REMOVE_AT) begin
					at = pos;
				end
				if (count_q == '0 || at >= count_q) begin
					status = ST_IGNORED;
				end else begin
					rem_ok = 1'b1;
				end
			end
			OP_GET: begin
				if (pos >= count_q) begin
					status = ST_IGNORED;
					result = GET_FAIL_VALUE;
				end else begin
					result = cell_data[req_q.position[IDX_W-1:0]];
				end
			end
			default: begin
			end
		endcase
	end

	// count update
	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_nxt;
		end
	end

	// shift command to the cell row
	always_comb begin
		sh.ins = exec && ins_ok;
		sh.rem = exec && rem_ok;
		sh.at  = at;
		sh.v   = req_q.value_in;
	end

	// cell row, each cell fed by its neighbors, zero past either end
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] below;
		logic signed [DATA_W-1:0] above;

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign above = '0;
		end else begin : g_mid_hi
			assign above = cell_data[i+1];
		end

		ils_cell u_cell (
			.clk   (clk),
			.idx   (CNT_W'(i)),
			.sh    (sh),
			.below (below),
			.above (above),
			.data  (cell_data[i])
		);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q.value_out     <= result;
			rsp_q.element_count <= count_nxt;
			rsp_q.status        <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/ils_checker.sv]
`timescale 1ns / 1ps

module ils_checker import ils_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input ils_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input ils_rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.element_count <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// full status only with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.element_count == CNT_W'(CAPACITY))
		else $error("full status with free cells");

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
